// ===== hw/rtl/dct_8_point_forward_top_defines.svh =====
// ----------------------------------------------------------------------------
// dct 8-point forward transform assertion macros
// shared property templates for the block checker
// ----------------------------------------------------------------------------
`ifndef DCT_8_POINT_FORWARD_TOP_DEFINES_SVH
`define DCT_8_POINT_FORWARD_TOP_DEFINES_SVH

// same-cycle implication, masked during reset
`define DCT8F_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dct8f check failed");

// next-cycle implication, masked during reset
`define DCT8F_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dct8f check failed");

// next-cycle implication, also checked through reset
`define DCT8F_ASSERT_NEXT_NORST(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("dct8f reset check failed");

`endif

// ===== hw/rtl/dct8f_pkg.sv =====
// ----------------------------------------------------------------------------
// dct8f_pkg
// shared constants, types and fixed-point helpers of the 8-point forward dct
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dct8f_pkg;

    localparam int SAMPLE_BITS_DEF    = 12;
    localparam int COEF_FRAC_BITS_DEF = 14;
    localparam int COEF_W             = 14;
    localparam int PIPE_STAGES        = 8;
    localparam int TABLE_FRAC_BITS    = 20;
    localparam int ROUND_W            = 62;

    localparam int COEF_MAX = 2 ** (COEF_W - 1) - 1;
    localparam int COEF_MIN = -(2 ** (COEF_W - 1));

    // round(cos(k pi / 16) / 2 * 2^20), k = 1..7
    localparam int COS_Q20 [7] = '{514214, 484379, 435930, 370728, 291279, 200636, 102284};

    typedef logic signed [COEF_W-1:0]  coef_t;
    typedef logic signed [ROUND_W-1:0] round_t;

    function automatic int quant_const(input int k, input int frac);
        int q;
        int sh;
        q  = COS_Q20[k-1];
        sh = TABLE_FRAC_BITS - frac;
        if (sh <= 0) begin
            return q;
        end
        return (q + (1 << (sh - 1))) >>> sh;
    endfunction

    // round half up, then clamp to the coefficient range
    function automatic coef_t round_sat(input round_t v, input int frac);
        logic signed [ROUND_W:0] half;
        logic signed [ROUND_W:0] sum;
        logic signed [ROUND_W:0] r;
        half = '0;
        half[frac-1] = 1'b1;
        sum = (ROUND_W + 1)'(v) + half;
        r = sum >>> frac;
        if (r > COEF_MAX) begin
            return coef_t'(COEF_MAX);
        end
        if (r < COEF_MIN) begin
            return coef_t'(COEF_MIN);
        end
        return coef_t'(r);
    endfunction

endpackage

// ===== hw/rtl/dct8f_pipe_ctrl.sv =====
// ----------------------------------------------------------------------------
// dct8f_pipe_ctrl
// valid bits and per-stage load enables of the transform pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dct8f_pipe_ctrl (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [dct8f_pkg::PIPE_STAGES-1:0]   stage_en
);

    localparam int N = dct8f_pkg::PIPE_STAGES;

    logic [N-1:0] valid_reg;
    logic [N-1:0] valid_next;
    logic [N-1:0] en;

    // a stage loads when it is empty or its content moves on
    always_comb begin
        en[N-1] = !valid_reg[N-1] || m_ready;
        for (int i = N - 2; i >= 0; i--) begin
            en[i] = !valid_reg[i] || en[i+1];
        end
        valid_next[0] = en[0] ? s_valid : valid_reg[0];
        for (int i = 1; i < N; i++) begin
            valid_next[i] = en[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready  = en[0];
    assign m_valid  = valid_reg[N-1];
    assign stage_en = en;

endmodule

// ===== hw/rtl/dct8f_even.sv =====
// ----------------------------------------------------------------------------
// dct8f_even
// even half of the butterfly network: coefficients 0, 2, 4 and 6
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dct8f_even #(
    parameter int SAMPLE_BITS    = dct8f_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = dct8f_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic [dct8f_pkg::PIPE_STAGES-1:0] stage_en,
    input  logic signed [SAMPLE_BITS:0]       s07,
    input  logic signed [SAMPLE_BITS:0]       s16,
    input  logic signed [SAMPLE_BITS:0]       s25,
    input  logic signed [SAMPLE_BITS:0]       s34,
    output dct8f_pkg::coef_t                  coef_0,
    output dct8f_pkg::coef_t                  coef_2,
    output dct8f_pkg::coef_t                  coef_4,
    output dct8f_pkg::coef_t                  coef_6
);

    localparam int F  = COEF_FRAC_BITS;
    localparam int BW = SAMPLE_BITS + 1;
    localparam int CW = F + 2;
    localparam int AW = SAMPLE_BITS + F + 6;

    localparam logic signed [CW-1:0] K4 = CW'(dct8f_pkg::quant_const(4, F));
    localparam logic signed [CW-1:0] K6 = CW'(dct8f_pkg::quant_const(6, F));
    localparam logic signed [CW-1:0] K2PK6 =
        CW'(dct8f_pkg::quant_const(2, F) + dct8f_pkg::quant_const(6, F));
    localparam logic signed [CW-1:0] K2MK6 =
        CW'(dct8f_pkg::quant_const(2, F) - dct8f_pkg::quant_const(6, F));

    // stage 2: even butterflies
    logic signed [BW:0]   a0_reg, a1_reg, a2_reg, a3_reg;
    logic signed [BW:0]   a0_next, a1_next, a2_next, a3_next;
    // stage 3: sums feeding the rotations
    logic signed [BW+1:0] ev0_reg, ev1_reg, sum23_reg, a2_d_reg, a3_d_reg;
    logic signed [BW+1:0] ev0_next, ev1_next, sum23_next;
    // stage 4: products
    logic signed [AW-1:0] p0_reg, p4_reg, t_reg, pa_reg, pb_reg;
    logic signed [AW-1:0] p0_next, p4_next, t_next, pa_next, pb_next;
    // stage 5: full precision coefficients
    logic signed [AW-1:0] f0_reg, f2_reg, f4_reg, f6_reg;
    logic signed [AW-1:0] f2_next, f6_next;
    // stages 6 to 8: rounded values and delay
    dct8f_pkg::coef_t     c0_reg, c2_reg, c4_reg, c6_reg;
    dct8f_pkg::coef_t     c0_d_reg, c2_d_reg, c4_d_reg, c6_d_reg;
    dct8f_pkg::coef_t     c0_q_reg, c2_q_reg, c4_q_reg, c6_q_reg;

    always_comb begin
        a0_next    = (BW + 1)'(s07) + (BW + 1)'(s34);
        a1_next    = (BW + 1)'(s16) + (BW + 1)'(s25);
        a2_next    = (BW + 1)'(s16) - (BW + 1)'(s25);
        a3_next    = (BW + 1)'(s07) - (BW + 1)'(s34);
        ev0_next   = (BW + 2)'(a0_reg) + (BW + 2)'(a1_reg);
        ev1_next   = (BW + 2)'(a0_reg) - (BW + 2)'(a1_reg);
        sum23_next = (BW + 2)'(a2_reg) + (BW + 2)'(a3_reg);
        p0_next    = AW'(ev0_reg) * AW'(K4);
        p4_next    = AW'(ev1_reg) * AW'(K4);
        t_next     = AW'(sum23_reg) * AW'(K6);
        pa_next    = AW'(a2_d_reg) * AW'(K2PK6);
        pb_next    = AW'(a3_d_reg) * AW'(K2MK6);
        f6_next    = t_reg - pa_reg;
        f2_next    = t_reg + pb_reg;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            a0_reg <= a0_next;
            a1_reg <= a1_next;
            a2_reg <= a2_next;
            a3_reg <= a3_next;
        end
        if (stage_en[2]) begin
            ev0_reg   <= ev0_next;
            ev1_reg   <= ev1_next;
            sum23_reg <= sum23_next;
            a2_d_reg  <= (BW + 2)'(a2_reg);
            a3_d_reg  <= (BW + 2)'(a3_reg);
        end
        if (stage_en[3]) begin
            p0_reg <= p0_next;
            p4_reg <= p4_next;
            t_reg  <= t_next;
            pa_reg <= pa_next;
            pb_reg <= pb_next;
        end
        if (stage_en[4]) begin
            f0_reg <= p0_reg;
            f4_reg <= p4_reg;
            f2_reg <= f2_next;
            f6_reg <= f6_next;
        end
        if (stage_en[5]) begin
            c0_reg <= dct8f_pkg::round_sat(dct8f_pkg::ROUND_W'(f0_reg), F);
            c2_reg <= dct8f_pkg::round_sat(dct8f_pkg::ROUND_W'(f2_reg), F);
            c4_reg <= dct8f_pkg::round_sat(dct8f_pkg::ROUND_W'(f4_reg), F);
            c6_reg <= dct8f_pkg::round_sat(dct8f_pkg::ROUND_W'(f6_reg), F);
        end
        if (stage_en[6]) begin
            c0_d_reg <= c0_reg;
            c2_d_reg <= c2_reg;
            c4_d_reg <= c4_reg;
            c6_d_reg <= c6_reg;
        end
        if (stage_en[7]) begin
            c0_q_reg <= c0_d_reg;
            c2_q_reg <= c2_d_reg;
            c4_q_reg <= c4_d_reg;
            c6_q_reg <= c6_d_reg;
        end
    end

    assign coef_0 = c0_q_reg;
    assign coef_2 = c2_q_reg;
    assign coef_4 = c4_q_reg;
    assign coef_6 = c6_q_reg;

endmodule

// ===== hw/rtl/dct8f_odd.sv =====
// ----------------------------------------------------------------------------
// dct8f_odd
// odd half of the butterfly network: coefficients 1, 3, 5 and 7
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dct8f_odd #(
    parameter int SAMPLE_BITS    = dct8f_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = dct8f_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic [dct8f_pkg::PIPE_STAGES-1:0] stage_en,
    input  logic signed [SAMPLE_BITS:0]       e07,
    input  logic signed [SAMPLE_BITS:0]       e16,
    input  logic signed [SAMPLE_BITS:0]       e25,
    input  logic signed [SAMPLE_BITS:0]       e34,
    output dct8f_pkg::coef_t                  coef_1,
    output dct8f_pkg::coef_t                  coef_3,
    output dct8f_pkg::coef_t                  coef_5,
    output dct8f_pkg::coef_t                  coef_7
);

    localparam int F  = COEF_FRAC_BITS;
    localparam int BW = SAMPLE_BITS + 1;
    localparam int CW = F + 2;
    localparam int AW = SAMPLE_BITS + F + 6;
    localparam int PW = AW + CW;

    localparam int Q1 = dct8f_pkg::quant_const(1, F);
    localparam int Q3 = dct8f_pkg::quant_const(3, F);
    localparam int Q4 = dct8f_pkg::quant_const(4, F);
    localparam int Q5 = dct8f_pkg::quant_const(5, F);
    localparam int Q7 = dct8f_pkg::quant_const(7, F);

    localparam logic signed [CW-1:0] K3    = CW'(Q3);
    localparam logic signed [CW-1:0] K7    = CW'(Q7);
    localparam logic signed [CW-1:0] K1PK7 = CW'(Q1 + Q7);
    localparam logic signed [CW-1:0] K1MK7 = CW'(Q1 - Q7);
    localparam logic signed [CW-1:0] K5PK3 = CW'(Q5 + Q3);
    localparam logic signed [CW-1:0] K5MK3 = CW'(Q5 - Q3);
    localparam logic signed [CW-1:0] K4X2  = CW'(2 * Q4);

    // stage 2: rotation input sums
    logic signed [BW:0]   sa_reg, sb_reg, sa_next, sb_next;
    logic signed [BW-1:0] e07_reg, e16_reg, e25_reg, e34_reg;
    // stage 3: products
    logic signed [AW-1:0] t1_reg, ma_reg, mb_reg, t2_reg, mc_reg, md_reg;
    logic signed [AW-1:0] t1_next, ma_next, mb_next, t2_next, mc_next, md_next;
    // stage 4: rotated values
    logic signed [AW-1:0] b4_reg, b5_reg, b6_reg, b7_reg;
    logic signed [AW-1:0] b4_next, b5_next, b6_next, b7_next;
    // stage 5: outer sums and differences
    logic signed [AW-1:0] o1_reg, o7_reg, u5_reg, u6_reg;
    logic signed [AW-1:0] o1_next, o7_next, u5_next, u6_next;
    // stage 6
    dct8f_pkg::coef_t     c1_reg, c7_reg;
    logic signed [AW-1:0] d35_reg, s35_reg, d35_next, s35_next;
    // stage 7
    dct8f_pkg::coef_t     c1_d_reg, c7_d_reg;
    logic signed [PW-1:0] p3_reg, p5_reg, p3_next, p5_next;
    // stage 8
    dct8f_pkg::coef_t     c1_q_reg, c3_q_reg, c5_q_reg, c7_q_reg;

    always_comb begin
        sa_next  = (BW + 1)'(e34) + (BW + 1)'(e07);
        sb_next  = (BW + 1)'(e25) + (BW + 1)'(e16);
        t1_next  = AW'(sa_reg) * AW'(K7);
        ma_next  = AW'(e07_reg) * AW'(K1MK7);
        mb_next  = AW'(e34_reg) * AW'(K1PK7);
        t2_next  = AW'(sb_reg) * AW'(K3);
        mc_next  = AW'(e25_reg) * AW'(K5MK3);
        md_next  = AW'(e16_reg) * AW'(K5PK3);
        b4_next  = t1_reg + ma_reg;
        b7_next  = t1_reg - mb_reg;
        b5_next  = t2_reg + mc_reg;
        b6_next  = t2_reg - md_reg;
        o1_next  = b4_reg + b5_reg;
        o7_next  = b6_reg + b7_reg;
        u5_next  = b4_reg - b5_reg;
        u6_next  = b6_reg - b7_reg;
        d35_next = u5_reg - u6_reg;
        s35_next = u5_reg + u6_reg;
        p3_next  = PW'(d35_reg) * PW'(K4X2);
        p5_next  = PW'(s35_reg) * PW'(K4X2);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            sa_reg  <= sa_next;
            sb_reg  <= sb_next;
            e07_reg <= e07;
            e16_reg <= e16;
            e25_reg <= e25;
            e34_reg <= e34;
        end
        if (stage_en[2]) begin
            t1_reg <= t1_next;
            ma_reg <= ma_next;
            mb_reg <= mb_next;
            t2_reg <= t2_next;
            mc_reg <= mc_next;
            md_reg <= md_next;
        end
        if (stage_en[3]) begin
            b4_reg <= b4_next;
            b5_reg <= b5_next;
            b6_reg <= b6_next;
            b7_reg <= b7_next;
        end
        if (stage_en[4]) begin
            o1_reg <= o1_next;
            o7_reg <= o7_next;
            u5_reg <= u5_next;
            u6_reg <= u6_next;
        end
        if (stage_en[5]) begin
            c1_reg  <= dct8f_pkg::round_sat(dct8f_pkg::ROUND_W'(o1_reg), F);
            c7_reg  <= dct8f_pkg::round_sat(dct8f_pkg::ROUND_W'(o7_reg), F);
            d35_reg <= d35_next;
            s35_reg <= s35_next;
        end
        if (stage_en[6]) begin
            c1_d_reg <= c1_reg;
            c7_d_reg <= c7_reg;
            p3_reg   <= p3_next;
            p5_reg   <= p5_next;
        end
        if (stage_en[7]) begin
            c1_q_reg <= c1_d_reg;
            c7_q_reg <= c7_d_reg;
            c3_q_reg <= dct8f_pkg::round_sat(dct8f_pkg::ROUND_W'(p3_reg), 2 * F);
            c5_q_reg <= dct8f_pkg::round_sat(dct8f_pkg::ROUND_W'(p5_reg), 2 * F);
        end
    end

    assign coef_1 = c1_q_reg;
    assign coef_3 = c3_q_reg;
    assign coef_5 = c5_q_reg;
    assign coef_7 = c7_q_reg;

endmodule

// ===== hw/rtl/dct_8_point_forward_top.sv =====
// ----------------------------------------------------------------------------
// dct_8_point_forward_top
// orthonormal 8-point forward dct of one row of signed samples
//
// input channel s_*: one request carries the eight samples of a row,
//   taken when s_valid and s_ready are both high
// output channel m_*: one request carries the eight 14-bit coefficients,
//   rounded half up and saturated, taken when m_valid and m_ready are high
// throughput: one row per cycle until m_ready low fills the 8-stage butterfly pipeline
//   (input butterflies, sums, products, rotations, output sums,
//   rounding, scaling of coefficients 3 and 5, final rounding)
// reset: aresetn low empties the pipeline; m_valid drops on the next edge
// stall: with m_ready low the stages fill up behind the output register;
//   empty stages still take new rows, s_ready drops only when all are full
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dct_8_point_forward_top #(
    parameter int SAMPLE_BITS    = dct8f_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = dct8f_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_0,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_1,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_2,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_3,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_4,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_5,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_6,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_7,
    output logic                          m_valid,
    input  logic                          m_ready,
    output dct8f_pkg::coef_t              m_coef_0,
    output dct8f_pkg::coef_t              m_coef_1,
    output dct8f_pkg::coef_t              m_coef_2,
    output dct8f_pkg::coef_t              m_coef_3,
    output dct8f_pkg::coef_t              m_coef_4,
    output dct8f_pkg::coef_t              m_coef_5,
    output dct8f_pkg::coef_t              m_coef_6,
    output dct8f_pkg::coef_t              m_coef_7
);

    localparam int BW = SAMPLE_BITS + 1;

    logic [dct8f_pkg::PIPE_STAGES-1:0] stage_en;

    logic signed [BW-1:0] s07_reg, s16_reg, s25_reg, s34_reg;
    logic signed [BW-1:0] e07_reg, e16_reg, e25_reg, e34_reg;
    logic signed [BW-1:0] s07_next, s16_next, s25_next, s34_next;
    logic signed [BW-1:0] e07_next, e16_next, e25_next, e34_next;

    dct8f_pipe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .stage_en (stage_en)
    );

    // stage 1: input butterflies
    always_comb begin
        s07_next = BW'(s_sample_0) + BW'(s_sample_7);
        s16_next = BW'(s_sample_1) + BW'(s_sample_6);
        s25_next = BW'(s_sample_2) + BW'(s_sample_5);
        s34_next = BW'(s_sample_3) + BW'(s_sample_4);
        e07_next = BW'(s_sample_0) - BW'(s_sample_7);
        e16_next = BW'(s_sample_1) - BW'(s_sample_6);
        e25_next = BW'(s_sample_2) - BW'(s_sample_5);
        e34_next = BW'(s_sample_3) - BW'(s_sample_4);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            s07_reg <= s07_next;
            s16_reg <= s16_next;
            s25_reg <= s25_next;
            s34_reg <= s34_next;
            e07_reg <= e07_next;
            e16_reg <= e16_next;
            e25_reg <= e25_next;
            e34_reg <= e34_next;
        end
    end

    dct8f_even #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_even (
        .aclk     (aclk),
        .stage_en (stage_en),
        .s07      (s07_reg),
        .s16      (s16_reg),
        .s25      (s25_reg),
        .s34      (s34_reg),
        .coef_0   (m_coef_0),
        .coef_2   (m_coef_2),
        .coef_4   (m_coef_4),
        .coef_6   (m_coef_6)
    );

    dct8f_odd #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_odd (
        .aclk     (aclk),
        .stage_en (stage_en),
        .e07      (e07_reg),
        .e16      (e16_reg),
        .e25      (e25_reg),
        .e34      (e34_reg),
        .coef_1   (m_coef_1),
        .coef_3   (m_coef_3),
        .coef_5   (m_coef_5),
        .coef_7   (m_coef_7)
    );

endmodule

// ===== hw/rtl/dct8f_checker.sv =====
// ----------------------------------------------------------------------------
// dct8f_checker
// port-level checks of the 8-point forward dct, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dct_8_point_forward_top_defines.svh"

module dct8f_checker (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input dct8f_pkg::coef_t m_coef_0,
    input dct8f_pkg::coef_t m_coef_3
);

    // a pending result is not dropped, and its coefficients 0 and 3 do not change
    `DCT8F_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
    `DCT8F_ASSERT_NEXT(a_out_stable, aclk, aresetn, m_valid && !m_ready, $stable(m_coef_0) && $stable(m_coef_3))

    // reset empties the pipeline
    `DCT8F_ASSERT_NEXT_NORST(a_reset_empty, aclk, !aresetn, !m_valid)

    // a free output stage or a taking receiver lets the input advance
    `DCT8F_ASSERT_IMPL(a_in_open, aclk, aresetn, !m_valid || m_ready, s_ready)

endmodule

bind dct_8_point_forward_top dct8f_checker u_dct8f_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_coef_0 (m_coef_0),
    .m_coef_3 (m_coef_3)
);

// ===== bench/dct_8_point_forward_top_tb.sv =====
// ----------------------------------------------------------------------------
// dct_8_point_forward_top_tb
// self-checking bench for the 8-point forward dct: rows are sent over the
// s_ channel and every m_ coefficient row is compared with a bit-exact
// fixed-point model of the butterfly network, first on directed extreme and
// impulse rows, then on random rows with and without random idling on both
// sides
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dct_8_point_forward_top_tb;

    localparam int SAMPLE_W   = 12;
    localparam int FRAC       = 14;
    localparam int LATENCY    = 8;
    localparam int SAMPLE_MAX = 2047;
    localparam int SAMPLE_MIN = -2048;

    // cosine constants quantized from 20 to 14 fraction bits
    localparam longint K1 = (514214 + 32) >>> 6;
    localparam longint K2 = (484379 + 32) >>> 6;
    localparam longint K3 = (435930 + 32) >>> 6;
    localparam longint K4 = (370728 + 32) >>> 6;
    localparam longint K5 = (291279 + 32) >>> 6;
    localparam longint K6 = (200636 + 32) >>> 6;
    localparam longint K7 = (102284 + 32) >>> 6;

    typedef logic [7:0][SAMPLE_W-1:0]        sample_row_t;
    typedef logic [7:0][dct8f_pkg::COEF_W-1:0] coef_row_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [SAMPLE_W-1:0] s_sample_0 = '0;
    logic signed [SAMPLE_W-1:0] s_sample_1 = '0;
    logic signed [SAMPLE_W-1:0] s_sample_2 = '0;
    logic signed [SAMPLE_W-1:0] s_sample_3 = '0;
    logic signed [SAMPLE_W-1:0] s_sample_4 = '0;
    logic signed [SAMPLE_W-1:0] s_sample_5 = '0;
    logic signed [SAMPLE_W-1:0] s_sample_6 = '0;
    logic signed [SAMPLE_W-1:0] s_sample_7 = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    dct8f_pkg::coef_t m_coef_0, m_coef_1, m_coef_2, m_coef_3;
    dct8f_pkg::coef_t m_coef_4, m_coef_5, m_coef_6, m_coef_7;

    coef_row_t coef_rows_pending[$];
    int        error_count = 0;
    bit        tx_idle_on  = 1'b0;
    bit        rx_stall_on = 1'b0;

    dct_8_point_forward_top #(
        .SAMPLE_BITS   (SAMPLE_W),
        .COEF_FRAC_BITS(FRAC)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_sample_0(s_sample_0),
        .s_sample_1(s_sample_1),
        .s_sample_2(s_sample_2),
        .s_sample_3(s_sample_3),
        .s_sample_4(s_sample_4),
        .s_sample_5(s_sample_5),
        .s_sample_6(s_sample_6),
        .s_sample_7(s_sample_7),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_coef_0  (m_coef_0),
        .m_coef_1  (m_coef_1),
        .m_coef_2  (m_coef_2),
        .m_coef_3  (m_coef_3),
        .m_coef_4  (m_coef_4),
        .m_coef_5  (m_coef_5),
        .m_coef_6  (m_coef_6),
        .m_coef_7  (m_coef_7)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        #2ms;
        $display("Test completed with failures");
        $finish;
    end

    // round half up at the given fraction width, then clamp to 14 bits
    function automatic logic [dct8f_pkg::COEF_W-1:0] round_clip(input longint v,
                                                                 input int frac);
        longint r;
        r = (v + (64'sd1 <<< (frac - 1))) >>> frac;
        if (r > dct8f_pkg::COEF_MAX) r = longint'(dct8f_pkg::COEF_MAX);
        if (r < dct8f_pkg::COEF_MIN) r = longint'(dct8f_pkg::COEF_MIN);
        return r[dct8f_pkg::COEF_W-1:0];
    endfunction

    function automatic coef_row_t dct_of_row(input sample_row_t row);
        longint    d[8];
        longint    s07, s16, s25, s34, e34, e25, e16, e07;
        longint    a0, a1, a2, a3, t, b4, b5, b6, b7, u5, u6;
        coef_row_t c;
        for (int i = 0; i < 8; i++) d[i] = longint'($signed(row[i]));
        s07 = d[0] + d[7];
        s16 = d[1] + d[6];
        s25 = d[2] + d[5];
        s34 = d[3] + d[4];
        e34 = d[3] - d[4];
        e25 = d[2] - d[5];
        e16 = d[1] - d[6];
        e07 = d[0] - d[7];
        a0 = s07 + s34;
        a1 = s16 + s25;
        a2 = s16 - s25;
        a3 = s07 - s34;
        t  = K7 * (e34 + e07);
        b4 = t + e07 * (K1 - K7);
        b7 = t - e34 * (K1 + K7);
        t  = K3 * (e25 + e16);
        b5 = t + e25 * (K5 - K3);
        b6 = t - e16 * (K5 + K3);
        c[0] = round_clip(K4 * (a0 + a1), FRAC);
        c[4] = round_clip(K4 * (a0 - a1), FRAC);
        t    = K6 * (a2 + a3);
        c[6] = round_clip(t - a2 * (K2 + K6), FRAC);
        c[2] = round_clip(t + a3 * (K2 - K6), FRAC);
        c[1] = round_clip(b4 + b5, FRAC);
        c[7] = round_clip(b6 + b7, FRAC);
        u5 = b4 - b5;
        u6 = b6 - b7;
        c[3] = round_clip(2 * K4 * (u5 - u6), 2 * FRAC);
        c[5] = round_clip(2 * K4 * (u5 + u6), 2 * FRAC);
        return c;
    endfunction

    // one request per call; valid stays high into the next call unless an idle gap is taken
    task automatic send_row(input sample_row_t row);
        s_valid    <= 1'b1;
        s_sample_0 <= row[0];
        s_sample_1 <= row[1];
        s_sample_2 <= row[2];
        s_sample_3 <= row[3];
        s_sample_4 <= row[4];
        s_sample_5 <= row[5];
        s_sample_6 <= row[6];
        s_sample_7 <= row[7];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        coef_rows_pending.push_back(dct_of_row(row));
        if (tx_idle_on && $urandom_range(99) < 6) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    function automatic logic [SAMPLE_W-1:0] random_sample(input int kind);
        int v;
        case (kind)
            0: v = $urandom_range(4095);
            1: v = int'($urandom_range(32)) - 16;
            default: begin
                case ($urandom_range(5))
                    0: v = SAMPLE_MAX;
                    1: v = SAMPLE_MAX - 1;
                    2: v = SAMPLE_MIN;
                    3: v = SAMPLE_MIN + 1;
                    4: v = 0;
                    default: v = -1;
                endcase
            end
        endcase
        return v[SAMPLE_W-1:0];
    endfunction

    function automatic sample_row_t random_row();
        sample_row_t row;
        int          kind;
        kind = $urandom_range(9);
        for (int i = 0; i < 8; i++) begin
            if (kind < 6) row[i] = random_sample(0);
            else if (kind < 8) row[i] = random_sample(1);
            else if (kind < 9) row[i] = random_sample(2);
            else row[i] = random_sample($urandom_range(2));
        end
        return row;
    endfunction

    // result checker
    always @(posedge aclk) begin
        coef_row_t got;
        coef_row_t want;
        got = {m_coef_7, m_coef_6, m_coef_5, m_coef_4,
               m_coef_3, m_coef_2, m_coef_1, m_coef_0};
        if (aresetn && m_valid && m_ready) begin
            if (coef_rows_pending.size() == 0) begin
                $display("%0t: unexpected coefficient row %h", $time, got);
                error_count++;
            end else begin
                want = coef_rows_pending.pop_front();
                for (int i = 0; i < 8; i++) begin
                    if (got[i] !== want[i]) begin
                        $display("%0t: coef_%0d expected %0d actual %0d", $time, i,
                                 $signed(want[i]), $signed(got[i]));
                        error_count++;
                    end
                end
            end
        end
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= !rx_stall_on || ($urandom_range(99) >= 6);
    end

    task automatic test_directed_extremes();
        sample_row_t row;
        tx_idle_on  = 1'b0;
        rx_stall_on = 1'b0;
        send_row('0);
        for (int i = 0; i < 8; i++) row[i] = SAMPLE_MAX[SAMPLE_W-1:0];
        send_row(row);
        for (int i = 0; i < 8; i++) row[i] = SAMPLE_MIN[SAMPLE_W-1:0];
        send_row(row);
        for (int i = 0; i < 8; i++) row[i] = SAMPLE_W'((i % 2) ? SAMPLE_MIN : SAMPLE_MAX);
        send_row(row);
        for (int i = 0; i < 8; i++) row[i] = SAMPLE_W'((i % 2) ? SAMPLE_MAX : SAMPLE_MIN);
        send_row(row);
        for (int i = 0; i < 8; i++) row[i] = SAMPLE_W'((i < 4) ? SAMPLE_MAX : SAMPLE_MIN);
        send_row(row);
        for (int i = 0; i < 8; i++) row[i] = SAMPLE_W'((i * 585) - 2048);
        send_row(row);
    endtask

    task automatic test_impulses();
        sample_row_t row;
        for (int i = 0; i < 8; i++) begin
            row    = '0;
            row[i] = SAMPLE_MIN[SAMPLE_W-1:0];
            send_row(row);
        end
        for (int i = 0; i < 8; i += 7) begin
            row    = '0;
            row[i] = SAMPLE_MAX[SAMPLE_W-1:0];
            send_row(row);
        end
    endtask

    task automatic test_random_back_to_back(input int count);
        tx_idle_on  = 1'b0;
        rx_stall_on = 1'b0;
        repeat (count) send_row(random_row());
    endtask

    task automatic test_random_with_stalls(input int count);
        tx_idle_on  = 1'b1;
        rx_stall_on = 1'b1;
        repeat (count) send_row(random_row());
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_extremes();
        test_impulses();
        test_random_with_stalls(700);
        test_random_back_to_back(400);
        test_random_with_stalls(700);
        s_valid <= 1'b0;
        while (coef_rows_pending.size() != 0) @(posedge aclk);
        repeat (2 * LATENCY) @(posedge aclk);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
